### hw/rtl/fkm_pkg.sv
// shared constants, types and helper functions of the fuzzy key table match
`default_nettype none

package fkm_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int KEY_CHARS     = 8;
  localparam int CHAR_W        = 8;
  localparam int WORD_W        = 64;
  localparam int WORD_CHARS    = WORD_W / CHAR_W;
  localparam int LEN_W         = 4;
  localparam int SLOT_W        = 5;
  localparam int ENTRY_W       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int PROD_W        = 2 * LEN_W;
  localparam int OUTCOME_W     = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 4;

  localparam logic [LEN_W-1:0]     KEY_CHARS_LEN = LEN_W'(KEY_CHARS);
  localparam logic [CFG_IDX_W-1:0] CFG_NUM       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DEN       = CFG_IDX_W'(1);
  localparam logic [CFG_DATA_W-1:0] NUM_RESET    = CFG_DATA_W'(3);
  localparam logic [CFG_DATA_W-1:0] DEN_RESET    = CFG_DATA_W'(5);

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_NONE    = 2'd0,
    OUT_EXACT   = 2'd1,
    OUT_SUGGEST = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [WORD_W-1:0]  query;
    logic [LEN_W-1:0]   len;
    logic [ENTRY_W-1:0] cur;
    logic               exact;
    logic [ENTRY_W-1:0] exact_idx;
    logic               have;
    logic [ENTRY_W-1:0] best_idx;
    logic [LEN_W-1:0]   best_m;
    logic [LEN_W-1:0]   best_l;
  } tok_t;

  function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    return (len > KEY_CHARS_LEN) ? KEY_CHARS_LEN : len;
  endfunction

  function automatic logic [WORD_W-1:0] keep_chars(input logic [WORD_W-1:0] chars,
                                                   input logic [LEN_W-1:0]  len);
    logic [WORD_W-1:0] w;
    w = '0;
    for (int p = 0; p < WORD_CHARS; p++) begin
      if (LEN_W'(p) < len) begin
        w[p*CHAR_W +: CHAR_W] = chars[p*CHAR_W +: CHAR_W];
      end
    end
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] upper_word(input logic [WORD_W-1:0] chars);
    logic [WORD_W-1:0] w;
    for (int p = 0; p < WORD_CHARS; p++) begin
      w[p*CHAR_W +: CHAR_W] = to_upper(chars[p*CHAR_W +: CHAR_W]);
    end
    return w;
  endfunction

  function automatic logic [SLOT_W-1:0] to_found(input logic [ENTRY_W-1:0] idx);
    logic [ENTRY_W+SLOT_W-1:0] ext;
    ext = (ENTRY_W+SLOT_W)'(idx);
    return ext[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/fkm_in_if.sv
// request channel carrying table writes and queries
`default_nettype none

interface fkm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [fkm_pkg::SLOT_W-1:0]   slot;
  logic [fkm_pkg::WORD_W-1:0]   word_chars;
  logic [fkm_pkg::LEN_W-1:0]    word_length;

  modport source (output valid, op, slot, word_chars, word_length, input ready);
  modport sink   (input valid, op, slot, word_chars, word_length, output ready);
endinterface

`default_nettype wire

### hw/rtl/fkm_out_if.sv
// result channel carrying one lookup result
`default_nettype none

interface fkm_out_if;
  logic                          valid;
  logic                          ready;
  logic [fkm_pkg::OUTCOME_W-1:0] outcome;
  logic [fkm_pkg::SLOT_W-1:0]    found_index;
  logic [fkm_pkg::LEN_W-1:0]     matched_chars;
  logic [fkm_pkg::LEN_W-1:0]     longer_length;

  modport source (output valid, outcome, found_index, matched_chars, longer_length,
                  input ready);
  modport sink   (input valid, outcome, found_index, matched_chars, longer_length,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/fkm_cfg_if.sv
// configuration write channel
`default_nettype none

interface fkm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fkm_pkg::CFG_IDX_W-1:0]  index;
  logic [fkm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/fkm_cell.sv
// one table entry with its compare logic and a stage of the query chain
`default_nettype none

module fkm_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [fkm_pkg::WORD_W-1:0]  wr_chars_i,
  input  logic [fkm_pkg::LEN_W-1:0]   wr_len_i,
  input  logic                        advance_i,
  input  logic                        valid_i,
  input  fkm_pkg::tok_t               tok_i,
  output logic                        valid_o,
  output fkm_pkg::tok_t               tok_o
);
  import fkm_pkg::*;

  logic [WORD_W-1:0] key_q;
  logic [LEN_W-1:0]  len_q;
  logic              valid_q;
  tok_t              tok_q;
  tok_t              tok_d;

  logic [LEN_W-1:0]  shorter;
  logic [LEN_W-1:0]  longer;
  logic [LEN_W-1:0]  m;
  logic              exact_hit;
  logic              better;
  logic [PROD_W-1:0] lhs;
  logic [PROD_W-1:0] rhs;

  always_comb begin
    shorter = (len_q < tok_i.len) ? len_q : tok_i.len;
    longer  = (len_q > tok_i.len) ? len_q : tok_i.len;
    m = '0;
    for (int p = 0; p < WORD_CHARS; p++) begin
      if (LEN_W'(p) < shorter &&
          to_upper(key_q[p*CHAR_W +: CHAR_W]) == tok_i.query[p*CHAR_W +: CHAR_W]) begin
        m = m + LEN_W'(1);
      end
    end
    exact_hit = (len_q != '0) && (len_q == tok_i.len) && (key_q == tok_i.query);
    lhs    = PROD_W'(m) * PROD_W'(tok_i.best_l);
    rhs    = PROD_W'(tok_i.best_m) * PROD_W'(longer);
    better = (len_q != '0) && (m != '0) && (!tok_i.have || lhs > rhs);

    tok_d     = tok_i;
    tok_d.cur = tok_i.cur + ENTRY_W'(1);
    if (!tok_i.exact && exact_hit) begin
      tok_d.exact     = 1'b1;
      tok_d.exact_idx = tok_i.cur;
    end
    if (better) begin
      tok_d.have     = 1'b1;
      tok_d.best_idx = tok_i.cur;
      tok_d.best_m   = m;
      tok_d.best_l   = longer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_q <= wr_chars_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        len_q <= wr_len_i;
      end
      if (advance_i) begin
        valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      tok_q <= tok_d;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

endmodule

`default_nettype wire

### hw/rtl/fkm_decide.sv
// threshold registers, final decision and result register
`default_nettype none

module fkm_decide (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  fkm_pkg::tok_t tok_i,
  output logic          take_o,
  fkm_cfg_if.sink       cfg_if,
  fkm_out_if.source     rsp_if
);
  import fkm_pkg::*;

  logic [CFG_DATA_W-1:0] num_q;
  logic [CFG_DATA_W-1:0] den_q;
  logic                  out_valid_q;
  logic [OUTCOME_W-1:0]  outcome_q;
  logic [SLOT_W-1:0]     index_q;
  logic [LEN_W-1:0]      matched_q;
  logic [LEN_W-1:0]      longer_q;

  logic [OUTCOME_W-1:0]  outcome_d;
  logic [SLOT_W-1:0]     index_d;
  logic [LEN_W-1:0]      matched_d;
  logic [LEN_W-1:0]      longer_d;
  logic [PROD_W-1:0]     lhs;
  logic [PROD_W-1:0]     rhs;
  logic                  take;

  assign take   = valid_i && (!out_valid_q || rsp_if.ready);
  assign take_o = take;

  always_comb begin
    lhs = PROD_W'(tok_i.best_m) * PROD_W'(den_q);
    rhs = PROD_W'(num_q) * PROD_W'(tok_i.best_l);
    outcome_d = OUT_NONE;
    index_d   = '0;
    matched_d = '0;
    longer_d  = '0;
    if (tok_i.exact) begin
      outcome_d = OUT_EXACT;
      index_d   = to_found(tok_i.exact_idx);
      matched_d = tok_i.len;
      longer_d  = tok_i.len;
    end else if (tok_i.have && lhs >= rhs) begin
      outcome_d = OUT_SUGGEST;
      index_d   = to_found(tok_i.best_idx);
      matched_d = tok_i.best_m;
      longer_d  = tok_i.best_l;
    end
  end

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q       <= NUM_RESET;
      den_q       <= DEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          CFG_NUM: num_q <= cfg_if.data;
          CFG_DEN: den_q <= cfg_if.data;
          default: ;
        endcase
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (rsp_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      outcome_q <= outcome_d;
      index_q   <= index_d;
      matched_q <= matched_d;
      longer_q  <= longer_d;
    end
  end

  assign rsp_if.valid         = out_valid_q;
  assign rsp_if.outcome       = outcome_q;
  assign rsp_if.found_index   = index_q;
  assign rsp_if.matched_chars = matched_q;
  assign rsp_if.longer_length = longer_q;

endmodule

`default_nettype wire

### hw/rtl/fuzzy_key_table_match.sv
// top level: key table as a chain of cells that a query token walks through
//
//   channel  dir  handshake      payload
//   req_if   in   valid/ready    op, slot, word_chars, word_length
//   rsp_if   out  valid/ready    outcome, found_index, matched_chars, longer_length
//   cfg_if   in   valid/ready    index, data (0 numerator, 1 denominator)
//
// a write request gives no result
// a query walks all TABLE_ENTRIES cells one per cycle while the chain tail is
// not stalled, then its result enters the output register; no further request
// is taken until the token is taken into the output register, so a query
// blocks longer while an earlier result still waits in the output register
// reset empties every slot and loads the threshold 3/5
// a stalled result holds the token at the chain tail until rsp_if.ready
`default_nettype none

module fuzzy_key_table_match (
  input  logic      clk_i,
  input  logic      rst_ni,
  fkm_in_if.sink    req_if,
  fkm_out_if.source rsp_if,
  fkm_cfg_if.sink   cfg_if
);
  import fkm_pkg::*;

  logic                     busy_q;
  logic                     req_fire;
  logic                     query_fire;
  logic                     write_fire;
  logic                     advance;
  logic                     take;
  logic [LEN_W-1:0]         len_c;
  logic [WORD_W-1:0]        chars_c;
  tok_t                     head_tok;
  logic [TABLE_ENTRIES:0]   vld;
  tok_t                     tok_c [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] wr_en;

  assign req_if.ready = !busy_q;
  assign req_fire     = req_if.valid && req_if.ready;
  assign query_fire   = req_fire && (req_if.op == OP_QUERY);
  assign write_fire   = req_fire && (req_if.op == OP_WRITE);

  assign len_c   = clamp_len(req_if.word_length);
  assign chars_c = keep_chars(req_if.word_chars, len_c);

  always_comb begin
    head_tok       = '0;
    head_tok.query = upper_word(chars_c);
    head_tok.len   = len_c;
  end

  assign vld[0]   = query_fire;
  assign tok_c[0] = head_tok;
  assign advance  = !vld[TABLE_ENTRIES] || take;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    assign wr_en[g] = write_fire &&
                      ((ENTRY_W+SLOT_W)'(req_if.slot) == (ENTRY_W+SLOT_W)'(g));
    fkm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (wr_en[g]),
      .wr_chars_i (chars_c),
      .wr_len_i   (len_c),
      .advance_i  (advance),
      .valid_i    (vld[g]),
      .tok_i      (tok_c[g]),
      .valid_o    (vld[g+1]),
      .tok_o      (tok_c[g+1])
    );
  end

  fkm_decide u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[TABLE_ENTRIES]),
    .tok_i   (tok_c[TABLE_ENTRIES]),
    .take_o  (take),
    .cfg_if  (cfg_if),
    .rsp_if  (rsp_if)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (query_fire) begin
      busy_q <= 1'b1;
    end else if (take) begin
      busy_q <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_query_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_fire |=> busy_q)
    else $error("query accepted without busy");

  a_idle_chain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (vld[TABLE_ENTRIES:1] == '0))
    else $error("token in chain while idle");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld[TABLE_ENTRIES:1]) <= 1)
    else $error("more than one token in chain");

  a_exact_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_if.valid && (rsp_if.outcome == OUT_EXACT) |->
      (rsp_if.matched_chars == rsp_if.longer_length))
    else $error("exact result with partial match");
`endif

endmodule

`default_nettype wire
